>>> design/grouped_cumulative_aggregate_defines.svh
// Assertion macros shared by the grouped cumulative aggregate modules.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef GROUPED_CUMULATIVE_AGGREGATE_DEFINES_SVH
`define GROUPED_CUMULATIVE_AGGREGATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GCA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gca: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gca: next-cycle check failed");

`endif

>>> design/gca_pkg.sv
// Shared types and constants for the grouped cumulative aggregate.
// Depends on nothing; imported by the controller, datapath and top level.
package gca_pkg;

    localparam int GROUP_COUNT_DEF = 1024;
    localparam int GI_W            = 11;
    localparam int VAL_W           = 64;
    localparam int HALF_W          = 32;
    localparam int OP_W            = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 2;
    localparam int FLAG_W          = 2;

    localparam logic [OP_W-1:0] OP_SUM  = 2'd0;
    localparam logic [OP_W-1:0] OP_PROD = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX  = 2'd2;
    localparam logic [OP_W-1:0] OP_MIN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_NULLS = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic read;
        logic load;
        logic mul0;
        logic mul1;
        logic mul2;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_mul;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> design/gca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/gca_ctrl.sv
// Controller state machine: clearing pass, row intake, multiply steps, result.
// Depends on gca_pkg and the assertion macros header.
`include "grouped_cumulative_aggregate_defines.svh"

module gca_ctrl
    import gca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = sts.need_mul ? ST_MUL0 : ST_DONE;
            end
            ST_MUL0:
            begin
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_MUL0:
            begin
                cmd.mul0 = 1'b1;
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
            end
            ST_MUL2:
            begin
                cmd.mul2 = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result may only be committed into a free output register.
    `GCA_ASSERT_NOW(a_finish_needs_slot, cmd.finish, sts.out_free)
    // No row is taken while the flag memory is still being cleared.
    `GCA_ASSERT_NOW(a_no_accept_in_clear, state_reg == ST_CLEAR, in_stall)
    // An accepted transaction always moves on to the memory read.
    `GCA_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall, cmd.read)
    // The multiply sequence always ends in the result state.
    `GCA_ASSERT_NEXT(a_mul_to_done, cmd.mul2, state_reg == ST_DONE)

endmodule

>>> design/gca_dp.sv
// Datapath: configuration registers, group memories, combine unit and output register.
// Depends on gca_pkg, gca_ram and the assertion macros header.
`include "grouped_cumulative_aggregate_defines.svh"

module gca_dp
    import gca_pkg::*;
#(
    parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic signed [GI_W-1:0]   group_index,
    input  logic signed [VAL_W-1:0]  value_in,
    input  logic                     value_present,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [VAL_W-1:0]  running_value,
    output logic                     running_present,
    input  ctrl_cmd_t                cmd,
    output ctrl_sts_t                sts
);

    localparam int AW = $clog2(GROUP_COUNT);
    localparam int KEY_W = GI_W - 1;

    // Configuration.
    logic [OP_W-1:0] op_mode_reg;
    logic            skip_nulls_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg    <= OP_SUM;
            skip_nulls_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OP_MODE:    op_mode_reg    <= cfg_data;
                REG_SKIP_NULLS: skip_nulls_reg <= cfg_data[0];
                default:        op_mode_reg    <= op_mode_reg;
            endcase
        end
    end

    // Clearing pass over the flag memory after reset.
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Captured row.
    logic [AW-1:0]            addr_reg;
    logic                     missing_reg;
    logic [VAL_W-1:0]         value_reg;
    logic                     present_reg;
    logic [AW+KEY_W-1:0]      addr_ext;

    assign addr_ext = {{AW{1'b0}}, group_index[KEY_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg    <= addr_ext[AW-1:0];
            missing_reg <= group_index[GI_W-1]
                           || (32'(group_index[KEY_W-1:0]) >= GROUP_COUNT);
            value_reg   <= value_in;
            present_reg <= value_present;
        end
    end

    // Group memories. Flags are {touched, null_seen}.
    logic                flag_we;
    logic [AW-1:0]       flag_waddr;
    logic [FLAG_W-1:0]   flag_wdata;
    logic [FLAG_W-1:0]   flag_rdata;
    logic                acc_we;
    logic [VAL_W-1:0]    acc_rdata;
    logic [VAL_W-1:0]    result;

    logic                touched_reg;
    logic                null_seen_reg;
    logic                combine_reg;
    logic                set_null_reg;
    logic [VAL_W-1:0]    acc_reg;

    assign flag_we    = cmd.clear || (cmd.finish && (combine_reg || set_null_reg));
    assign flag_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
    assign flag_wdata = cmd.clear ? '0
                      : (combine_reg ? {1'b1, null_seen_reg} : {touched_reg, 1'b1});
    assign acc_we     = cmd.finish && combine_reg;

    gca_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (GROUP_COUNT)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (flag_rdata)
    );

    gca_ram #(
        .WIDTH (VAL_W),
        .DEPTH (GROUP_COUNT)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (addr_reg),
        .wdata (result),
        .re    (cmd.read),
        .raddr (addr_reg),
        .rdata (acc_rdata)
    );

    // Decision on the row once the memories have answered.
    logic             combine_now;
    logic [VAL_W-1:0] identity;

    always_comb
    begin
        case (op_mode_reg)
            OP_SUM:  identity = '0;
            OP_PROD: identity = VAL_W'(1);
            OP_MAX:  identity = {1'b1, {(VAL_W-1){1'b0}}};
            OP_MIN:  identity = {1'b0, {(VAL_W-1){1'b1}}};
            default: identity = '0;
        endcase
    end

    assign combine_now = !missing_reg && present_reg && (skip_nulls_reg || !flag_rdata[0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            touched_reg   <= flag_rdata[1];
            null_seen_reg <= flag_rdata[0];
            combine_reg   <= combine_now;
            set_null_reg  <= !missing_reg && !present_reg && !skip_nulls_reg;
            acc_reg       <= flag_rdata[1] ? acc_rdata : identity;
        end
    end

    // Low 64 bits of the product from three 32x32 partial products.
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [VAL_W-1:0]  mul_reg;
    logic [VAL_W-1:0]  prod_reg;

    always_comb
    begin
        mul_a = value_reg[HALF_W-1:0];
        mul_b = acc_reg[HALF_W-1:0];
        if (cmd.mul1)
        begin
            mul_b = acc_reg[VAL_W-1:HALF_W];
        end
        else if (cmd.mul2)
        begin
            mul_a = value_reg[VAL_W-1:HALF_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul0 || cmd.mul1 || cmd.mul2)
        begin
            mul_reg <= mul_a * mul_b;
        end
        if (cmd.mul1)
        begin
            prod_reg <= mul_reg;
        end
        else if (cmd.mul2)
        begin
            prod_reg <= prod_reg + {mul_reg[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_comb
    begin
        case (op_mode_reg)
            OP_SUM:  result = value_reg + acc_reg;
            OP_PROD: result = prod_reg + {mul_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            OP_MAX:  result = ($signed(value_reg) < $signed(acc_reg)) ? acc_reg : value_reg;
            OP_MIN:  result = ($signed(acc_reg) < $signed(value_reg)) ? acc_reg : value_reg;
            default: result = value_reg;
        endcase
    end

    // Output register; it frees up in the same cycle it is taken.
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_value_reg   <= combine_reg ? result : '0;
            out_present_reg <= combine_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign running_value   = out_value_reg;
    assign running_present = out_present_reg;

    assign sts.clear_last = (clr_cnt_reg == AW'(GROUP_COUNT - 1));
    assign sts.need_mul   = combine_now && (op_mode_reg == OP_PROD);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // A new result only appears when the controller commits one.
    `GCA_ASSERT_NEXT(a_out_from_finish, !out_valid_reg && !cmd.finish, !out_valid_reg)
    // A row that is combined never also marks its group as poisoned.
    `GCA_ASSERT_NOW(a_one_update_kind, cmd.finish, !(combine_reg && set_null_reg))

endmodule

>>> design/grouped_cumulative_aggregate.sv
// Top level of the grouped cumulative aggregate: controller plus datapath.
// Depends on gca_pkg, gca_ctrl and gca_dp.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------
//   cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall  | group_index, value_in, value_present
//   out     | out       | out_valid/out_stall| running_value, running_present
//
// A row passes from acceptance through the memory read and the load state to the result
// state, where it is committed to the output register; a combined product row first takes
// three passes through one 32x32 multiplier. The next row is taken once the controller is
// back in idle. Each row does one read of the group memories and at most one write to each.
// After reset a clearing pass over all GROUP_COUNT entries zeroes the group flags before the
// first row is taken. Output stalls hold the finished result; the block waits only when a
// second result is ready while the first is still stalled.
module grouped_cumulative_aggregate
    import gca_pkg::*;
#(
    parameter int GROUP_COUNT = GROUP_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [GI_W-1:0]   group_index,
    input  logic signed [VAL_W-1:0]  value_in,
    input  logic                     value_present,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [VAL_W-1:0]  running_value,
    output logic                     running_present
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    gca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gca_dp #(
        .GROUP_COUNT (GROUP_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .group_index     (group_index),
        .value_in        (value_in),
        .value_present   (value_present),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .running_value   (running_value),
        .running_present (running_present),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for grouped_cumulative_aggregate: random rows and idling on both sides,
// with a scoreboard class that tracks every group's running result to predict each output.
// Depends on gca_pkg and the grouped_cumulative_aggregate design sources.
module tb_top;
    import gca_pkg::*;

    localparam int IDLE_LIMIT     = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int ROWS_PER_PHASE = 170;
    localparam int PHASE_COUNT    = 10;
    localparam logic [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             present;
    } group_total_t;

    class aggregate_scoreboard;
        logic [VAL_W-1:0] totals [GROUP_COUNT_DEF];
        bit               touched [GROUP_COUNT_DEF];
        bit               poisoned [GROUP_COUNT_DEF];
        logic [OP_W-1:0]  op_mode;
        bit               skip_nulls;
        group_total_t     awaited [$];
        int               failures;

        function new();
            op_mode    = OP_SUM;
            skip_nulls = 1'b1;
            failures   = 0;
        endfunction

        function logic [VAL_W-1:0] start_value(logic [OP_W-1:0] op);
            case (op)
                OP_SUM:  return '0;
                OP_PROD: return VAL_W'(1);
                OP_MAX:  return MOST_NEG;
                default: return MOST_POS;
            endcase
        endfunction

        function logic [VAL_W-1:0] fold_row(logic [OP_W-1:0] op, logic [VAL_W-1:0] v,
                                            logic [VAL_W-1:0] acc);
            logic [VAL_W-1:0] product;
            product = v * acc;
            case (op)
                OP_SUM:  return v + acc;
                OP_PROD: return product;
                OP_MAX:  return ($signed(v) < $signed(acc)) ? acc : v;
                default: return ($signed(acc) < $signed(v)) ? acc : v;
            endcase
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_OP_MODE)
                op_mode = data[OP_W-1:0];
            else
                skip_nulls = data[0];
        endfunction

        // Called for every accepted input transaction; queues the result it must produce.
        function void note_row(logic [GI_W-1:0] gi, logic [VAL_W-1:0] v, logic present);
            group_total_t     want;
            logic [VAL_W-1:0] acc;
            int               g;
            want.value   = '0;
            want.present = 1'b0;
            // A set top bit is a negative index, which is a missing key.
            if (!gi[GI_W-1]) begin
                g   = int'(gi[GI_W-2:0]);
                acc = touched[g] ? totals[g] : start_value(op_mode);
                if (!present) begin
                    if (!skip_nulls)
                        poisoned[g] = 1'b1;
                end
                else if (skip_nulls || !poisoned[g]) begin
                    want.value   = fold_row(op_mode, v, acc);
                    want.present = 1'b1;
                    totals[g]    = want.value;
                    touched[g]   = 1'b1;
                end
            end
            awaited = {awaited, want};
        endfunction

        function void check_result(logic [VAL_W-1:0] v, logic present);
            group_total_t want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result: value %h present %b", v, present);
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value || present !== want.present) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected value %h present %b, got value %h present %b",
                             want.value, want.present, v, present);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_OP_MODE;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [GI_W-1:0]  group_index = '0;
    logic signed [VAL_W-1:0] value_in = '0;
    logic                    value_present = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] running_value;
    logic                    running_present;

    aggregate_scoreboard sb;
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    int idle_cycles = 0;

    grouped_cumulative_aggregate u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .group_index     (group_index),
        .value_in        (value_in),
        .value_present   (value_present),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .running_value   (running_value),
        .running_present (running_present)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic [VAL_W-1:0] draw_value();
        logic signed [VAL_W-1:0] tiny_v;
        tiny_v = VAL_W'($urandom_range(0, 8));
        tiny_v = tiny_v - 4;
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2, 3:    return tiny_v;
            4:       return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a few hot groups at both ends of the table, so that rows of one group
    // follow each other closely; the rest spread out or carry a missing key.
    function automatic logic [GI_W-1:0] draw_group();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '1;
        if (pick < 8)
            return {1'b1, 10'($urandom)};
        if (pick < 28)
            return GI_W'($urandom_range(0, GROUP_COUNT_DEF - 1));
        pick = $urandom_range(0, 7);
        return GI_W'((pick < 4) ? pick : GROUP_COUNT_DEF - 8 + pick);
    endfunction

    // Leaves in_valid high after the transaction so that a zero gap keeps it high.
    task automatic send_row(logic [GI_W-1:0] gi, logic [VAL_W-1:0] v, logic present);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        group_index   <= gi;
        value_in      <= v;
        value_present <= present;
        in_valid      <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_row(gi, v, present);
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_mode(logic [OP_W-1:0] op, bit skip);
        logic [CFG_IDX_W-1:0]  idx [2];
        logic [CFG_DATA_W-1:0] data [2];
        idx[0]  = REG_OP_MODE;
        data[0] = CFG_DATA_W'(op);
        idx[1]  = REG_SKIP_NULLS;
        data[1] = CFG_DATA_W'(skip);
        wait_for_drain();
        cfg_valid <= 1'b1;
        for (int k = 0; k < 2; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(idx[k], data[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [OP_W-1:0] op;
        bit              skip;
        logic            present;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sum with nulls skipped. Wraparound at both ends, missing keys.
        send_row(11'd0, MOST_POS, 1'b1);
        send_row(11'd0, VAL_W'(1), 1'b1);
        send_row(11'd1023, MOST_NEG, 1'b1);
        send_row(11'd1023, '1, 1'b1);
        send_row('1, VAL_W'(123), 1'b1);
        send_row({1'b1, 10'd0}, VAL_W'(5), 1'b1);
        send_row(11'd5, VAL_W'(77), 1'b0);
        send_row(11'd5, VAL_W'(3), 1'b1);
        send_row(11'd0, '0, 1'b0);

        // Product with poisoning; group 0 keeps its sum across the change of operation.
        program_mode(OP_PROD, 1'b0);
        send_row(11'd0, VAL_W'(2), 1'b1);
        send_row(11'd6, '1, 1'b1);
        send_row(11'd6, MOST_POS, 1'b1);
        send_row(11'd6, VAL_W'(9), 1'b0);
        send_row(11'd6, VAL_W'(4), 1'b1);
        send_row(11'd7, 64'h0000_0001_0000_0003, 1'b1);
        send_row(11'd7, 64'h0000_0001_0000_0003, 1'b1);
        send_row(11'd7, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1);

        // Max in skip mode ignores the poison mark on group 6.
        program_mode(OP_MAX, 1'b1);
        send_row(11'd6, VAL_W'(10), 1'b1);
        send_row(11'd8, MOST_NEG, 1'b1);
        send_row(11'd8, 64'hFFFF_FFFF_FFFF_FFFB, 1'b1);

        // Min in poison mode: the old mark on group 6 applies again.
        program_mode(OP_MIN, 1'b0);
        send_row(11'd6, VAL_W'(1), 1'b1);
        send_row(11'd9, MOST_POS, 1'b1);
        send_row(11'd9, 64'hFFFF_FFFF_FFFF_FFF9, 1'b1);
        send_row(11'd9, '0, 1'b1);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p < 8) begin
                op   = OP_W'(p >> 1);
                skip = p[0];
            end
            else begin
                op   = OP_W'($urandom_range(0, 3));
                skip = 1'($urandom_range(0, 1));
            end
            program_mode(op, skip);
            for (int r = 0; r < ROWS_PER_PHASE; r++) begin
                // Poison mode gets few nulls, or every hot group would go null at once.
                present = skip ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 24) != 0);
                send_row(draw_group(), draw_value(), present);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: after each transaction, hold stall high for a drawn number of cycles.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(running_value, running_present);
                hold = draw_wait(take_calm);
                if ($urandom_range(0, 39) == 0)
                    take_calm = !take_calm;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> files.f
+incdir+design
design/gca_pkg.sv
design/gca_ram.sv
design/gca_ctrl.sv
design/gca_dp.sv
design/grouped_cumulative_aggregate.sv
bench/tb_top.sv
